>>> design/fpeh_pkg.sv
// ----------------------------------------------------------------------------
// fpeh_pkg
// Shared sizes, codes and transaction types of the filtered pair-energy
// histogram.
// ----------------------------------------------------------------------------
package fpeh_pkg;

  localparam int NUM_BINS  = 64;
  localparam int MAX_ATOMS = 65536;

  localparam int ATOM_AW   = $clog2(MAX_ATOMS);
  localparam int BIN_AW    = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int CLR_DEPTH = (MAX_ATOMS > NUM_BINS) ? MAX_ATOMS : NUM_BINS;
  localparam int CLR_AW    = $clog2(CLR_DEPTH);

  localparam int DIV_STEPS = 32;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

  localparam int CFG_AW    = 4;

  // Transaction kinds
  localparam logic [1:0] MODE_ATOM = 2'd0;
  localparam logic [1:0] MODE_PAIR = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  // Atom classes
  localparam logic [1:0] CLS_NONE = 2'd0;
  localparam logic [1:0] CLS_O    = 2'd1;
  localparam logic [1:0] CLS_H    = 2'd2;

  // Register indexes
  localparam logic [1:0] REG_BIN_LOW   = 2'd0;
  localparam logic [1:0] REG_BIN_WIDTH = 2'd1;
  localparam logic [1:0] REG_OXYGEN    = 2'd2;
  localparam logic [1:0] REG_HYDROGEN  = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_CLS_A,
    ST_CLS_B,
    ST_DIVIDE,
    ST_BIN,
    ST_DONE
  } fpeh_state_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic [15:0]        atom_a;
    logic [15:0]        atom_b;
    logic [7:0]         atom_type;
    logic signed [31:0] energy;
    logic [5:0]         bin_select;
  } fpeh_in_t;

  typedef struct packed {
    logic               matched;
    logic               in_range;
    logic [5:0]         bin_index;
    logic signed [31:0] low_energy;
    logic signed [31:0] high_energy;
    logic               seen_any;
    logic [31:0]        bin_count;
  } fpeh_out_t;

endpackage

>>> design/filtered_pair_energy_histogram_core.sv
// ----------------------------------------------------------------------------
// filtered_pair_energy_histogram_core
// Classifies atoms as O or H and histograms the energies of O-H pairs.
// ----------------------------------------------------------------------------
// After reset the block sweeps both stores to zero, one entry a cycle, from a
// counter over CLR_DEPTH (65536) addresses, and holds in_ready low meanwhile;
// the APB port takes register writes throughout. Transactions are then
// handled one at a time. An atom record or an unused mode goes from dispatch
// straight to the output register, a bin read by way of the ST_BIN state. A
// pair sample looks up both atom classes and ends there when it does not
// match, its energy lies below the first bin or the width is zero; otherwise
// the bin index comes from a restoring divider that produces one quotient bit
// per cycle, followed by a read-modify-write of the bin count, which is
// skipped when the energy lies at or past the top edge. The next transaction
// can be accepted in the cycle after the result is loaded. Atom classes live
// in a memory of MAX_ATOMS entries with one read port, so the two atoms of a
// pair are looked up in consecutive cycles. The result register lets the next
// transaction be accepted while the previous result still waits for
// out_ready; a finished transaction waits only while that register is full.
// ----------------------------------------------------------------------------
module filtered_pair_energy_histogram_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  fpeh_pkg::fpeh_in_t    in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output fpeh_pkg::fpeh_out_t   out_data,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [fpeh_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);
  import fpeh_pkg::*;

  // Configuration registers
  logic signed [31:0] bin_low_r;
  logic [30:0]        bin_width_r;
  logic [7:0]         oxygen_type_r;
  logic [7:0]         hydrogen_type_r;
  logic               cfg_wr;

  // Control
  fpeh_state_t        state_r, state_nxt;
  logic [CLR_AW-1:0]  clr_cnt_r;
  logic [DIV_CW-1:0]  div_cnt_r;

  // Held transaction and working values
  fpeh_in_t           item_r;
  logic [1:0]         cls_a_r;
  logic [31:0]        quo_r, quo_nxt;
  logic [30:0]        rem_r, rem_nxt;
  logic [BIN_AW-1:0]  bin_addr_r;
  logic signed [31:0] min_r, max_r;
  logic               seen_r;
  logic               res_matched_r;
  logic               res_in_range_r;
  logic [5:0]         res_idx_r;
  logic [31:0]        res_count_r;
  logic               out_valid_r;
  fpeh_out_t          out_data_r;

  // Memories
  logic [1:0]         cls_mem [MAX_ATOMS];
  logic [31:0]        bin_mem [NUM_BINS];
  logic               cls_we;
  logic [ATOM_AW-1:0] cls_waddr, cls_raddr;
  logic [1:0]         cls_wdata, cls_rdata_r;
  logic               bin_we;
  logic [BIN_AW-1:0]  bin_waddr, bin_raddr;
  logic [31:0]        bin_wdata, bin_rdata_r;

  // Decoded values
  logic               a_ok, b_ok, sel_ok, clr_last, slot_free;
  logic [1:0]         rec_cls, ca, cb;
  logic               has_o, has_h, match;
  logic signed [32:0] diff;
  logic               diff_ok;
  logic [31:0]        rem_sh;
  logic               ge;
  logic [31:0]        bin_inc;

  // --------------------------------------------------------------------------
  // APB register file: write on the access phase, read straight back.
  // --------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_low_r       <= 32'sd0;
      bin_width_r     <= 31'd65536;
      oxygen_type_r   <= 8'd1;
      hydrogen_type_r <= 8'd2;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_BIN_LOW:   bin_low_r       <= cfg_pwdata;
        REG_BIN_WIDTH: bin_width_r     <= cfg_pwdata[30:0];
        REG_OXYGEN:    oxygen_type_r   <= cfg_pwdata[7:0];
        REG_HYDROGEN:  hydrogen_type_r <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_BIN_LOW:   cfg_prdata = bin_low_r;
      REG_BIN_WIDTH: cfg_prdata = {1'b0, bin_width_r};
      REG_OXYGEN:    cfg_prdata = {24'd0, oxygen_type_r};
      REG_HYDROGEN:  cfg_prdata = {24'd0, hydrogen_type_r};
      default:       cfg_prdata = 32'd0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Decode. Ids at or beyond MAX_ATOMS have no class and records for them are
  // dropped; a pair naming one id twice is a single atom and never matches.
  // --------------------------------------------------------------------------
  assign a_ok      = 32'(item_r.atom_a) < 32'(MAX_ATOMS);
  assign b_ok      = 32'(item_r.atom_b) < 32'(MAX_ATOMS);
  assign sel_ok    = 32'(item_r.bin_select) < 32'(NUM_BINS);
  assign clr_last  = clr_cnt_r == CLR_AW'(CLR_DEPTH - 1);
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    if (item_r.atom_type == oxygen_type_r) begin
      rec_cls = CLS_O;
    end else if (item_r.atom_type == hydrogen_type_r) begin
      rec_cls = CLS_H;
    end else begin
      rec_cls = CLS_NONE;
    end
  end

  // Class of atom a was captured last cycle; class of atom b arrives now.
  assign ca    = a_ok ? cls_a_r : CLS_NONE;
  assign cb    = b_ok ? cls_rdata_r : CLS_NONE;
  assign has_o = (ca == CLS_O) || (cb == CLS_O);
  assign has_h = (ca == CLS_H) || (cb == CLS_H);
  assign match = has_o && has_h && (item_r.atom_a != item_r.atom_b);

  // Exact 33-bit difference; a zero width puts nothing in any bin.
  assign diff    = {item_r.energy[31], item_r.energy} - {bin_low_r[31], bin_low_r};
  assign diff_ok = !diff[32] && (bin_width_r != 31'd0);

  // One restoring divide step: the dividend shifts out of quo_r from the top
  // while quotient bits shift in at the bottom.
  assign rem_sh  = {rem_r, quo_r[31]};
  assign ge      = rem_sh >= {1'b0, bin_width_r};
  assign rem_nxt = ge ? 31'(rem_sh - {1'b0, bin_width_r}) : rem_sh[30:0];
  assign quo_nxt = {quo_r[30:0], ge};

  // Saturating increment of the bin just read.
  assign bin_inc = (bin_rdata_r == 32'hFFFF_FFFF) ? bin_rdata_r : bin_rdata_r + 32'd1;

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        case (item_r.mode)
          MODE_PAIR: state_nxt = ST_CLS_A;
          MODE_READ: state_nxt = sel_ok ? ST_BIN : ST_DONE;
          default:   state_nxt = ST_DONE;
        endcase
      end
      ST_CLS_A: state_nxt = ST_CLS_B;
      ST_CLS_B: begin
        state_nxt = (match && diff_ok) ? ST_DIVIDE : ST_DONE;
      end
      ST_DIVIDE: begin
        if (div_cnt_r == DIV_CW'(0)) begin
          state_nxt = (quo_nxt < 32'(NUM_BINS)) ? ST_BIN : ST_DONE;
        end
      end
      ST_BIN:  state_nxt = ST_DONE;
      ST_DONE: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // --------------------------------------------------------------------------
  // Outputs: handshake and memory port controls
  // --------------------------------------------------------------------------
  always_comb begin
    in_ready  = state_r == ST_IDLE;

    cls_we    = 1'b0;
    cls_waddr = ATOM_AW'(item_r.atom_a);
    cls_wdata = rec_cls;
    cls_raddr = ATOM_AW'(item_r.atom_a);

    bin_we    = 1'b0;
    bin_waddr = bin_addr_r;
    bin_wdata = bin_inc;
    bin_raddr = BIN_AW'(item_r.bin_select);

    case (state_r)
      ST_CLEAR: begin
        // Sweep both stores to zero from the same counter.
        cls_we    = 32'(clr_cnt_r) < 32'(MAX_ATOMS);
        cls_waddr = ATOM_AW'(clr_cnt_r);
        cls_wdata = CLS_NONE;
        bin_we    = 32'(clr_cnt_r) < 32'(NUM_BINS);
        bin_waddr = BIN_AW'(clr_cnt_r);
        bin_wdata = 32'd0;
      end
      ST_DISPATCH: begin
        cls_we = (item_r.mode == MODE_ATOM) && a_ok;
      end
      ST_CLS_A: begin
        cls_raddr = ATOM_AW'(item_r.atom_b);
      end
      ST_DIVIDE: begin
        bin_raddr = BIN_AW'(quo_nxt);
      end
      ST_BIN: begin
        // Write back only for a pair; a read leaves the count alone.
        bin_we = item_r.mode == MODE_PAIR;
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Memories: one write and one registered read each per cycle. Every
  // transaction finishes its write before the next one reads, so no
  // forwarding is needed.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (cls_we) cls_mem[cls_waddr] <= cls_wdata;
    cls_rdata_r <= cls_mem[cls_raddr];
  end

  always_ff @(posedge clk) begin
    if (bin_we) bin_mem[bin_waddr] <= bin_wdata;
    bin_rdata_r <= bin_mem[bin_raddr];
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      min_r       <= 32'sd0;
      max_r       <= 32'sd0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_cnt_r <= clr_cnt_r + CLR_AW'(1);

      // Track the extremes of matched energies; the first match seeds both.
      if (state_r == ST_CLS_B && match) begin
        seen_r <= 1'b1;
        if (!seen_r || item_r.energy < min_r) min_r <= item_r.energy;
        if (!seen_r || item_r.energy > max_r) max_r <= item_r.energy;
      end

      if (state_r == ST_DONE && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) item_r <= in_data;

    case (state_r)
      ST_DISPATCH: begin
        res_matched_r  <= 1'b0;
        res_in_range_r <= 1'b0;
        res_idx_r      <= (item_r.mode == MODE_READ) ? item_r.bin_select : 6'd0;
        res_count_r    <= 32'd0;
        bin_addr_r     <= BIN_AW'(item_r.bin_select);
      end
      ST_CLS_A: begin
        cls_a_r <= cls_rdata_r;
      end
      ST_CLS_B: begin
        res_matched_r <= match;
        quo_r         <= diff[31:0];
        rem_r         <= 31'd0;
        div_cnt_r     <= DIV_CW'(DIV_STEPS - 1);
      end
      ST_DIVIDE: begin
        quo_r      <= quo_nxt;
        rem_r      <= rem_nxt;
        div_cnt_r  <= div_cnt_r - DIV_CW'(1);
        bin_addr_r <= BIN_AW'(quo_nxt);
      end
      ST_BIN: begin
        if (item_r.mode == MODE_PAIR) begin
          res_in_range_r <= 1'b1;
          res_idx_r      <= 6'(bin_addr_r);
          res_count_r    <= bin_inc;
        end else begin
          res_count_r    <= bin_rdata_r;
        end
      end
      default: ;
    endcase

    // Hold the result until the consumer takes it.
    if (state_r == ST_DONE && slot_free) begin
      out_data_r.matched     <= res_matched_r;
      out_data_r.in_range    <= res_in_range_r;
      out_data_r.bin_index   <= res_idx_r;
      out_data_r.low_energy  <= min_r;
      out_data_r.high_energy <= max_r;
      out_data_r.seen_any    <= seen_r;
      out_data_r.bin_count   <= res_count_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the filtered pair-energy histogram core.
//
// Atom records, pair samples and bin reads are driven through the input
// channel. Each accepted transaction goes through a local model of the atom
// classes, the 64 bin counts and the running minimum and maximum. Every
// result is checked field by field against the oldest prediction still
// outstanding. A short directed part covers the bin edges, the register
// extremes and the odd cases. A long random part follows, under several
// register settings and several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
  import fpeh_pkg::*;

  // The 2-bit mode field has one code left over; the core treats it as a no-op
  localparam logic [1:0] MODE_SPARE = 2'd3;

  localparam int POOL_SIZE     = 24;   // atom ids that random traffic reuses
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 163;  // about 1300 random transactions in all
  localparam int MAX_GAP       = 30;
  localparam int MAX_REPORTS   = 100;
  localparam int TAIL_CYCLES   = 64;   // longer than the slowest pair sample

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  fpeh_in_t    in_data;
  logic        out_valid;
  logic        out_ready = 1'b0;
  fpeh_out_t   out_data;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Model of the core: register copies and both stores
  logic signed [31:0] bin_low_m;
  logic [30:0]        width_m;
  logic [7:0]         oxygen_m;
  logic [7:0]         hydrogen_m;
  logic [1:0]         atom_class_m [MAX_ATOMS];
  logic [31:0]        bin_count_m  [NUM_BINS];
  logic signed [31:0] min_energy_m;
  logic signed [31:0] max_energy_m;
  logic               seen_m;

  // Predicted readouts, oldest first
  fpeh_out_t histogram_readouts_q[$];
  fpeh_out_t want_r;

  int idle_pct;
  int stall_pct;
  int mismatch_count;

  logic [15:0] id_pool [POOL_SIZE];

  filtered_pair_energy_histogram_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Model
  // --------------------------------------------------------------------------

  // Work out the readout of one transaction and advance the model state.
  function automatic fpeh_out_t classify_and_bin(input fpeh_in_t t);
    fpeh_out_t r;
    logic [1:0] cls_a;
    logic [1:0] cls_b;
    logic       has_o;
    logic       has_h;
    longint     diff;
    longint     quot;
    int         slot;
    r = '0;
    case (t.mode)
      MODE_ATOM: begin
        // Oxygen wins when both type registers hold the same number
        if (t.atom_type == oxygen_m)
          atom_class_m[t.atom_a] = CLS_O;
        else if (t.atom_type == hydrogen_m)
          atom_class_m[t.atom_a] = CLS_H;
        else
          atom_class_m[t.atom_a] = CLS_NONE;
      end
      MODE_PAIR: begin
        cls_a = atom_class_m[t.atom_a];
        cls_b = atom_class_m[t.atom_b];
        has_o = (cls_a == CLS_O) || (cls_b == CLS_O);
        has_h = (cls_a == CLS_H) || (cls_b == CLS_H);
        // One id twice is one atom of one class, never a pair
        if (t.atom_a != t.atom_b && has_o && has_h) begin
          r.matched = 1'b1;
          if (!seen_m) begin
            min_energy_m = t.energy;
            max_energy_m = t.energy;
            seen_m       = 1'b1;
          end else begin
            if ($signed(t.energy) < min_energy_m) min_energy_m = t.energy;
            if ($signed(t.energy) > max_energy_m) max_energy_m = t.energy;
          end
          // Exact 33-bit difference; truncation is floor since it is non-negative
          diff = longint'($signed(t.energy)) - longint'(bin_low_m);
          if (diff >= 0 && width_m != '0) begin
            quot = diff / longint'(width_m);
            if (quot < NUM_BINS) begin
              slot = int'(quot);
              if (bin_count_m[slot] != '1)
                bin_count_m[slot] = bin_count_m[slot] + 32'd1;
              r.in_range  = 1'b1;
              r.bin_index = slot[5:0];
              r.bin_count = bin_count_m[slot];
            end
          end
        end
      end
      MODE_READ: begin
        r.bin_index = t.bin_select;
        r.bin_count = bin_count_m[t.bin_select];
      end
      default: ;
    endcase
    r.low_energy  = min_energy_m;
    r.high_energy = max_energy_m;
    r.seen_any    = seen_m;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t ns mismatch: %s", $time, what);
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // Sample on the edge itself: all drivers update by nonblocking assignment,
  // so these are the values that the handshake saw.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready) begin
      if (histogram_readouts_q.size() == 0) begin
        report_mismatch("readout with no transaction outstanding");
      end else begin
        want_r = histogram_readouts_q.pop_front();
        compare_field("matched",     32'(out_data.matched),   32'(want_r.matched));
        compare_field("in_range",    32'(out_data.in_range),  32'(want_r.in_range));
        compare_field("bin_index",   32'(out_data.bin_index), 32'(want_r.bin_index));
        compare_field("low_energy",  out_data.low_energy,     want_r.low_energy);
        compare_field("high_energy", out_data.high_energy,    want_r.high_energy);
        compare_field("seen_any",    32'(out_data.seen_any),  32'(want_r.seen_any));
        compare_field("bin_count",   out_data.bin_count,      want_r.bin_count);
      end
    end
  end

  // Receiver: stall at random, at the rate the current phase sets
  always @(posedge clk)
    out_ready <= ($urandom_range(99) >= stall_pct);

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Hand one transaction to the core, with an optional idle gap in front.
  // Valid stays high after acceptance so that back-to-back transactions
  // need no dead cycle; settle() drops it when the stream pauses.
  task automatic send_transaction(input fpeh_in_t t);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
      gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    histogram_readouts_q.push_back(classify_and_bin(t));
  endtask

  // Drop valid and hold until every outstanding readout has come back.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (histogram_readouts_q.size() != 0) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic program_register(input logic [1:0] index, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {index, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (index)
      REG_BIN_LOW:   bin_low_m  = value;
      REG_BIN_WIDTH: width_m    = value[30:0];
      REG_OXYGEN:    oxygen_m   = value[7:0];
      REG_HYDROGEN:  hydrogen_m = value[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Transaction builders: unused fields carry random bits.
  function automatic fpeh_in_t random_fields();
    fpeh_in_t t;
    t.mode       = MODE_ATOM;
    t.atom_a     = 16'($urandom);
    t.atom_b     = 16'($urandom);
    t.atom_type  = 8'($urandom);
    t.energy     = $urandom;
    t.bin_select = 6'($urandom);
    return t;
  endfunction

  function automatic fpeh_in_t record_item(input logic [15:0] id, input logic [7:0] kind);
    fpeh_in_t t;
    t           = random_fields();
    t.mode      = MODE_ATOM;
    t.atom_a    = id;
    t.atom_type = kind;
    return t;
  endfunction

  function automatic fpeh_in_t pair_item(input logic [15:0] a, input logic [15:0] b,
                                         input logic [31:0] energy);
    fpeh_in_t t;
    t        = random_fields();
    t.mode   = MODE_PAIR;
    t.atom_a = a;
    t.atom_b = b;
    t.energy = energy;
    return t;
  endfunction

  function automatic fpeh_in_t read_item(input logic [5:0] sel);
    fpeh_in_t t;
    t            = random_fields();
    t.mode       = MODE_READ;
    t.bin_select = sel;
    return t;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset settings: bins of 1.0 from 0.0, oxygen type 1, hydrogen type 2.
  task automatic test_atom_classes_and_reads();
    fpeh_in_t t;
    send_transaction(record_item(16'h0000, 8'd1));    // O
    send_transaction(record_item(16'hFFFF, 8'd2));    // H
    send_transaction(record_item(16'h0005, 8'hFF));   // no class
    send_transaction(record_item(16'h0007, 8'h00));   // no class
    send_transaction(read_item(6'd0));
    send_transaction(read_item(6'd63));
    // First match seeds both minimum and maximum
    send_transaction(pair_item(16'h0000, 16'hFFFF, 32'h0000_0000));
    // Just under the top edge lands in the last bin
    send_transaction(pair_item(16'hFFFF, 16'h0000, 32'h003F_FFFF));
    // Top edge itself falls outside, yet the maximum moves
    send_transaction(pair_item(16'h0000, 16'hFFFF, 32'h0040_0000));
    // Below the first bin: no count, minimum moves
    send_transaction(pair_item(16'h0000, 16'hFFFF, 32'hFFFF_FFFF));
    send_transaction(pair_item(16'h0000, 16'h0000, 32'h0001_0000));  // same atom
    send_transaction(pair_item(16'h0000, 16'h0005, 32'h0001_0000));  // O with none
    t      = random_fields();
    t.mode = MODE_SPARE;
    send_transaction(t);
    send_transaction(read_item(6'd63));
  endtask

  // Edges of the binning at the register extremes.
  task automatic test_bin_edges();
    settle();
    program_register(REG_BIN_LOW,   32'h0000_0000);
    program_register(REG_BIN_WIDTH, 32'h0000_0001);
    send_transaction(pair_item(16'h0000, 16'hFFFF, 32'd63));
    send_transaction(pair_item(16'h0000, 16'hFFFF, 32'd64));
    settle();
    program_register(REG_BIN_LOW, 32'h7FFF_FFFF);
    send_transaction(pair_item(16'hFFFF, 16'h0000, 32'h7FFF_FFFF));
    send_transaction(pair_item(16'hFFFF, 16'h0000, 32'h8000_0000));
    settle();
    program_register(REG_BIN_LOW,   32'h8000_0000);
    program_register(REG_BIN_WIDTH, 32'h7FFF_FFFF);
    send_transaction(pair_item(16'h0000, 16'hFFFF, 32'h7FFF_FFFF));
    send_transaction(pair_item(16'h0000, 16'hFFFF, 32'h8000_0000));
  endtask

  // A zero width leaves every matched energy outside the bins. Bit 31 of the
  // write data lies beyond the register and must be dropped.
  task automatic test_zero_width();
    settle();
    program_register(REG_BIN_WIDTH, 32'h8000_0000);
    send_transaction(pair_item(16'h0000, 16'hFFFF, 32'h1234_5678));
  endtask

  // Type registers at their extremes, then both equal so that oxygen wins.
  task automatic test_type_registers();
    settle();
    program_register(REG_BIN_LOW,   32'h0000_0000);
    program_register(REG_BIN_WIDTH, 32'h0001_0000);
    program_register(REG_OXYGEN,    32'hFFFF_FFFF);
    program_register(REG_HYDROGEN,  32'hFFFF_FF00);
    send_transaction(record_item(16'h0009, 8'hFF));
    send_transaction(record_item(16'h000A, 8'h00));
    send_transaction(pair_item(16'h0009, 16'h000A, 32'h0002_8000));
    settle();
    program_register(REG_HYDROGEN, 32'h0000_00FF);
    send_transaction(record_item(16'h000B, 8'hFF));
    send_transaction(pair_item(16'h000A, 16'h000B, 32'h0003_0000));
  endtask

  // Long random run: mostly records and pairs on a small pool of atom ids so
  // that matches are frequent, energies aimed around the configured bins,
  // plus reads, the spare mode and pure noise.
  task automatic test_random_traffic();
    fpeh_in_t    t;
    int          roll;
    int          step;
    longint      target;
    logic [31:0] low_v;
    logic [31:0] width_v;
    logic [7:0]  oxy_v;
    logic [7:0]  hyd_v;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      case (p)
        0: begin
          low_v = 32'h0000_0000; width_v = 32'h0001_0000; oxy_v = 8'd1; hyd_v = 8'd2;
        end
        1: begin
          low_v = 32'h8000_0000; width_v = 32'h7FFF_FFFF;
          oxy_v = 8'($urandom); hyd_v = 8'($urandom);
        end
        2: begin
          low_v = 32'h7FFF_FFC0; width_v = 32'h0000_0001; oxy_v = 8'hFF; hyd_v = 8'h00;
        end
        3: begin
          // Equal type numbers: every typed record becomes oxygen
          low_v = $urandom; width_v = $urandom_range(1 << 20, 1);
          oxy_v = 8'($urandom); hyd_v = oxy_v;
        end
        default: begin
          low_v   = $urandom;
          width_v = $urandom_range(1) ? $urandom_range(1 << 22, 1) : ($urandom | 32'd1);
          oxy_v   = 8'($urandom);
          hyd_v   = 8'($urandom);
        end
      endcase
      // Spare upper bits of the write data must be ignored
      program_register(REG_BIN_LOW,   low_v);
      program_register(REG_BIN_WIDTH, {1'($urandom), width_v[30:0]});
      program_register(REG_OXYGEN,    {24'($urandom), oxy_v});
      program_register(REG_HYDROGEN,  {24'($urandom), hyd_v});

      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 67; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 67; end
        default: begin idle_pct = 26; stall_pct = 26; end
      endcase

      for (int i = 0; i < POOL_SIZE; i++)
        id_pool[i] = 16'($urandom);
      id_pool[0] = 16'h0000;
      id_pool[1] = 16'hFFFF;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Once, let the core run completely dry mid-stream
        if (p == 4 && n == PHASE_ITEMS / 2)
          settle();
        t    = random_fields();
        roll = $urandom_range(99);
        if (roll < 5) begin
          t.mode = 2'($urandom_range(3));
        end else if (roll < 10) begin
          t.mode = MODE_SPARE;
        end else if (roll < 35) begin
          t.mode = MODE_ATOM;
          if ($urandom_range(9) != 0)
            t.atom_a = id_pool[$urandom_range(POOL_SIZE - 1)];
          roll = $urandom_range(9);
          if (roll < 4)
            t.atom_type = oxygen_m;
          else if (roll < 8)
            t.atom_type = hydrogen_m;
        end else if (roll < 80) begin
          t.mode   = MODE_PAIR;
          t.atom_a = id_pool[$urandom_range(POOL_SIZE - 1)];
          t.atom_b = ($urandom_range(19) == 0) ? t.atom_a
                                               : id_pool[$urandom_range(POOL_SIZE - 1)];
          // Aim most energies from one bin below to a few bins above the range
          if ($urandom_range(4) != 0 && width_m != '0) begin
            step     = int'($urandom_range(66)) - 1;
            target   = longint'(bin_low_m) + longint'(step) * longint'(width_m)
                       + longint'($urandom_range(width_m - 31'd1));
            t.energy = target[31:0];
          end
        end else begin
          t.mode = MODE_READ;
        end
        send_transaction(t);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    idle_pct       = 0;
    stall_pct      = 0;
    mismatch_count = 0;

    // Model state after reset
    bin_low_m  = 32'sd0;
    width_m    = 31'd65536;
    oxygen_m   = 8'd1;
    hydrogen_m = 8'd2;
    for (int i = 0; i < MAX_ATOMS; i++) atom_class_m[i] = CLS_NONE;
    for (int i = 0; i < NUM_BINS; i++)  bin_count_m[i]  = '0;
    min_energy_m = '0;
    max_energy_m = '0;
    seen_m       = 1'b0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // The core clears its stores first; sends simply wait on in_ready
    test_atom_classes_and_reads();
    test_bin_edges();
    test_zero_width();
    test_type_registers();
    test_random_traffic();

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // Watchdog: the slowest legal run is well under a fifth of this
  initial begin
    #20000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
